// ===== rtl/qte_pkg.sv =====
package qte_pkg;

  localparam int QW        = 16;  // Q1.14 quaternion components
  localparam int PW        = 32;  // 16x16 products
  localparam int SW        = 35;  // atan2 arguments, Q.28
  localparam int ROOT_W    = 29;  // sqrt result, Q.28
  localparam int REM_W     = 57;  // radicand 2^56 - s^2
  localparam int CW        = 38;  // CORDIC x/y
  localparam int ZW        = 34;  // CORDIC angle, Q2.30
  localparam int PRW       = 62;  // angle times degree scale
  localparam int OW        = 16;  // output angle
  localparam int TABLE_LEN = 24;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [SW-1:0] ONE_Q28     = SW'(64'd268435456);
  localparam logic signed [SW-1:0] NEG_ONE_Q28 = -ONE_Q28;
  localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'd3373259426);
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'd1686629713);
  localparam logic signed [27:0]   DEG_Q20     = 28'sd60078979;

  // atan(2^-i) in Q2.30, truncated
  localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic signed [SW-1:0]     roll_y;
    logic signed [SW-1:0]     roll_x;
    logic signed [SW-1:0]     yaw_y;
    logic signed [SW-1:0]     yaw_x;
    logic signed [ROOT_W-1:0] s;
    logic                     sat;
    logic                     s_neg;
  } side_t;

  typedef struct packed {
    logic sat;
    logic s_neg;
  } pflag_t;

  typedef struct packed {
    logic signed [OW-1:0] roll;
    logic signed [OW-1:0] pitch;
    logic signed [OW-1:0] yaw;
    logic                 sat;
  } result_t;

  // left half-plane folded over by pi; zero vector flagged
  function automatic cordic_t cordic_prep(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    cordic_t r;
    r.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      r.x = -x;
      r.y = -y;
      r.z = (y >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      r.x = x;
      r.y = y;
      r.z = '0;
    end
    return r;
  endfunction

  function automatic logic signed [OW-1:0] sat16(logic signed [19:0] v);
    logic signed [OW-1:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[OW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/qte_sqrt_cell.sv =====
// One result bit of the integer square root, restoring form.
module qte_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [qte_pkg::REM_W-1:0]     rem_i,
  input  logic [qte_pkg::ROOT_W-1:0]    root_i,
  output logic                          valid_o,
  output logic [qte_pkg::REM_W-1:0]     rem_o,
  output logic [qte_pkg::ROOT_W-1:0]    root_o
);

  localparam int TW = qte_pkg::REM_W + 2;

  logic [TW-1:0]                 trial;
  logic                          fits;
  logic [qte_pkg::REM_W-1:0]     rem_d, rem_q;
  logic [qte_pkg::ROOT_W-1:0]    root_d, root_q;
  logic                          valid_q;

  // (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
  assign trial  = (TW'(root_i) << (K + 1)) + (TW'(1) << (2 * K));
  assign fits   = TW'(rem_i) >= trial;
  assign rem_d  = fits ? qte_pkg::REM_W'(TW'(rem_i) - trial) : rem_i;
  assign root_d = fits ? (root_i | (qte_pkg::ROOT_W'(1) << K)) : root_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

// ===== rtl/qte_cordic_cell.sv =====
// One vectoring micro-rotation.
module qte_cordic_cell #(
  parameter int I = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  qte_pkg::cordic_t c_i,
  output logic             valid_o,
  output qte_pkg::cordic_t c_o
);

  localparam logic signed [qte_pkg::ZW-1:0] ANG = qte_pkg::ZW'(qte_pkg::ATAN_TABLE[I]);

  logic signed [qte_pkg::CW-1:0] x, y, xs, ys;
  logic signed [qte_pkg::ZW-1:0] z;
  qte_pkg::cordic_t              c_d, c_q;
  logic                          valid_q;

  assign x  = c_i.x;
  assign y  = c_i.y;
  assign z  = c_i.z;
  assign xs = x >>> I;
  assign ys = y >>> I;

  always_comb begin
    c_d.zero = c_i.zero;
    if (y >= 0) begin
      c_d.x = x + ys;
      c_d.y = y - xs;
      c_d.z = z + ANG;
    end else begin
      c_d.x = x - ys;
      c_d.y = y + xs;
      c_d.z = z - ANG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign valid_o = valid_q;
  assign c_o     = c_q;

endmodule

// ===== rtl/quaternion_to_euler_angles_top.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    quat_w_i quat_x_i quat_y_i quat_z_i
// result    out        out_valid_o / out_stall_i  roll/pitch/yaw_angle_o pitch_saturated_o
// config    in         cfg_we_i                   cfg_wdata_i (angle unit)
//
// One transaction per cycle while in_stall_o is low. Pipeline: 4 product/sum stages,
// 29 root cells (one result bit each), CORDIC prep, CORDIC_STAGES rotation cells,
// 2 output scaling stages and the output register.
// rst_ni clears all valid bits and the unit register (radians).
// Pipeline freezes only when the skid register is full; one more transaction is taken
// while a finished result waits on out_stall_i.
module quaternion_to_euler_angles_top #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [qte_pkg::QW-1:0]  quat_w_i,
  input  logic signed [qte_pkg::QW-1:0]  quat_x_i,
  input  logic signed [qte_pkg::QW-1:0]  quat_y_i,
  input  logic signed [qte_pkg::QW-1:0]  quat_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [qte_pkg::OW-1:0]  roll_angle_o,
  output logic signed [qte_pkg::OW-1:0]  pitch_angle_o,
  output logic signed [qte_pkg::OW-1:0]  yaw_angle_o,
  output logic                           pitch_saturated_o
);

  localparam int SQ_LAT = qte_pkg::ROOT_W + 1;
  localparam int N      = CORDIC_STAGES;

  localparam logic signed [qte_pkg::ZW:0]    RAD_RND = (qte_pkg::ZW + 1)'(64'd65536);
  localparam logic signed [qte_pkg::PRW-1:0] DEG_RND = qte_pkg::PRW'(64'd1 << 42);
  localparam logic [qte_pkg::REM_W-1:0]      RAD_TOP = qte_pkg::REM_W'(1) << (qte_pkg::REM_W - 1);

  logic en;
  logic unit_q;

  // angle unit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= 1'b0;
    end else if (cfg_we_i) begin
      unit_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------- stage 1: products
  logic                          v1_q;
  logic signed [qte_pkg::PW-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_zz_q;
  logic signed [qte_pkg::PW-1:0] p_wy_q, p_zx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wx_q <= quat_w_i * quat_x_i;
      p_yz_q <= quat_y_i * quat_z_i;
      p_xx_q <= quat_x_i * quat_x_i;
      p_yy_q <= quat_y_i * quat_y_i;
      p_wz_q <= quat_w_i * quat_z_i;
      p_xy_q <= quat_x_i * quat_y_i;
      p_zz_q <= quat_z_i * quat_z_i;
      p_wy_q <= quat_w_i * quat_y_i;
      p_zx_q <= quat_z_i * quat_x_i;
    end
  end

  // ---------------------------------------------------------------- stage 2: atan2 arguments
  logic                          v2_q;
  logic signed [qte_pkg::SW-1:0] t_ry, t_rx, t_yy, t_yx, t_s;
  logic signed [qte_pkg::SW-1:0] ry_q, rx_q, yy_q, yx_q, s2_q;

  assign t_ry = qte_pkg::SW'(p_wx_q) + qte_pkg::SW'(p_yz_q);
  assign t_rx = qte_pkg::SW'(p_xx_q) + qte_pkg::SW'(p_yy_q);
  assign t_yy = qte_pkg::SW'(p_wz_q) + qte_pkg::SW'(p_xy_q);
  assign t_yx = qte_pkg::SW'(p_yy_q) + qte_pkg::SW'(p_zz_q);
  assign t_s  = qte_pkg::SW'(p_wy_q) - qte_pkg::SW'(p_zx_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ry_q <= t_ry <<< 1;
      rx_q <= qte_pkg::ONE_Q28 - (t_rx <<< 1);
      yy_q <= t_yy <<< 1;
      yx_q <= qte_pkg::ONE_Q28 - (t_yx <<< 1);
      s2_q <= t_s <<< 1;
    end
  end

  // ---------------------------------------------------------------- stage 3: s^2, clamp test
  logic                                  v3_q;
  logic signed [qte_pkg::ROOT_W-1:0]     s29;
  logic signed [2*qte_pkg::ROOT_W-1:0]   sq;
  logic [qte_pkg::REM_W-1:0]             sq_q;
  qte_pkg::side_t                        side3_q;

  assign s29 = s2_q[qte_pkg::ROOT_W-1:0];
  assign sq  = s29 * s29;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q           <= sq[qte_pkg::REM_W-1:0];
      side3_q.roll_y <= ry_q;
      side3_q.roll_x <= rx_q;
      side3_q.yaw_y  <= yy_q;
      side3_q.yaw_x  <= yx_q;
      side3_q.s      <= s29;
      side3_q.sat    <= (s2_q >= qte_pkg::ONE_Q28) || (s2_q <= qte_pkg::NEG_ONE_Q28);
      side3_q.s_neg  <= s2_q < 0;
    end
  end

  // ---------------------------------------------------------------- stage 4: radicand
  logic                      v4_q;
  logic [qte_pkg::REM_W-1:0] rem_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q <= RAD_TOP - sq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------- root cells
  logic [qte_pkg::REM_W-1:0]  rem_c  [qte_pkg::ROOT_W+1];
  logic [qte_pkg::ROOT_W-1:0] root_c [qte_pkg::ROOT_W+1];
  logic                       vld_c  [qte_pkg::ROOT_W+1];
  qte_pkg::side_t             side_line [SQ_LAT];

  assign rem_c[0]  = rem_q;
  assign root_c[0] = '0;
  assign vld_c[0]  = v4_q;

  for (genvar j = 0; j < qte_pkg::ROOT_W; j++) begin : g_root
    qte_sqrt_cell #(
      .K(qte_pkg::ROOT_W - 1 - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld_c[j]),
      .rem_i   (rem_c[j]),
      .root_i  (root_c[j]),
      .valid_o (vld_c[j+1]),
      .rem_o   (rem_c[j+1]),
      .root_o  (root_c[j+1])
    );
  end

  // roll/yaw arguments wait alongside the root
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_line[0] <= side3_q;
      for (int i = 1; i < SQ_LAT; i++) begin
        side_line[i] <= side_line[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- CORDIC prep
  qte_pkg::side_t   side_o;
  qte_pkg::cordic_t prep_r_q, prep_p_q, prep_y_q;
  qte_pkg::pflag_t  pf_q;
  logic             vp_q;

  assign side_o = side_line[SQ_LAT-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_r_q <= qte_pkg::cordic_prep(qte_pkg::CW'(side_o.roll_x),
                                       qte_pkg::CW'(side_o.roll_y));
      prep_y_q <= qte_pkg::cordic_prep(qte_pkg::CW'(side_o.yaw_x),
                                       qte_pkg::CW'(side_o.yaw_y));
      prep_p_q <= qte_pkg::cordic_prep(qte_pkg::CW'(root_c[qte_pkg::ROOT_W]),
                                       qte_pkg::CW'(side_o.s));
      pf_q.sat   <= side_o.sat;
      pf_q.s_neg <= side_o.s_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= vld_c[qte_pkg::ROOT_W];
    end
  end

  // ---------------------------------------------------------------- CORDIC cells
  qte_pkg::cordic_t cr [N+1];
  qte_pkg::cordic_t cp [N+1];
  qte_pkg::cordic_t cy [N+1];
  logic             vr [N+1];
  logic             vpc [N+1];
  logic             vy [N+1];
  qte_pkg::pflag_t  pf_line [N];

  assign cr[0]  = prep_r_q;
  assign cp[0]  = prep_p_q;
  assign cy[0]  = prep_y_q;
  assign vr[0]  = vp_q;
  assign vpc[0] = vp_q;
  assign vy[0]  = vp_q;

  for (genvar i = 0; i < N; i++) begin : g_cordic
    qte_cordic_cell #(.I(i)) u_roll (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(vr[i]), .c_i(cr[i]), .valid_o(vr[i+1]), .c_o(cr[i+1])
    );
    qte_cordic_cell #(.I(i)) u_pitch (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(vpc[i]), .c_i(cp[i]), .valid_o(vpc[i+1]), .c_o(cp[i+1])
    );
    qte_cordic_cell #(.I(i)) u_yaw (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(vy[i]), .c_i(cy[i]), .valid_o(vy[i+1]), .c_o(cy[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pf_line[0] <= pf_q;
      for (int i = 1; i < N; i++) begin
        pf_line[i] <= pf_line[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- final angles
  logic signed [qte_pkg::ZW-1:0] a_roll, a_pitch, a_yaw;
  qte_pkg::pflag_t               pf_o;
  logic                          vf;

  assign pf_o   = pf_line[N-1];
  assign vf     = vr[N] & vpc[N] & vy[N];
  assign a_roll = cr[N].zero ? '0 : cr[N].z;
  assign a_yaw  = cy[N].zero ? '0 : cy[N].z;

  always_comb begin
    if (pf_o.sat) begin
      a_pitch = pf_o.s_neg ? -qte_pkg::HALF_PI_Q30 : qte_pkg::HALF_PI_Q30;
    end else begin
      a_pitch = cp[N].zero ? '0 : cp[N].z;
    end
  end

  // ---------------------------------------------------------------- scaling, stage 1
  logic signed [qte_pkg::ZW-1:0]  ang_q  [3];
  logic signed [qte_pkg::PRW-1:0] prod_q [3];
  logic                           sat1_q, ve1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0]  <= a_roll;
      ang_q[1]  <= a_pitch;
      ang_q[2]  <= a_yaw;
      prod_q[0] <= a_roll * qte_pkg::DEG_Q20;
      prod_q[1] <= a_pitch * qte_pkg::DEG_Q20;
      prod_q[2] <= a_yaw * qte_pkg::DEG_Q20;
      sat1_q    <= pf_o.sat;
    end
  end

  // ---------------------------------------------------------------- scaling, stage 2: round, clamp
  logic signed [qte_pkg::ZW:0]    rsum [3];
  logic signed [qte_pkg::PRW-1:0] dsum [3];
  logic signed [qte_pkg::OW-1:0]  enc  [3];
  qte_pkg::result_t               res_q;
  logic                           ve2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum[k] = (qte_pkg::ZW + 1)'(ang_q[k]) + RAD_RND;
      dsum[k] = prod_q[k] + DEG_RND;
      if (unit_q) begin
        enc[k] = qte_pkg::sat16(20'(dsum[k] >>> 43));
      end else begin
        enc[k] = qte_pkg::sat16(20'(rsum[k] >>> 17));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.roll  <= enc[0];
      res_q.pitch <= enc[1];
      res_q.yaw   <= enc[2];
      res_q.sat   <= sat1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve1_q <= 1'b0;
      ve2_q <= 1'b0;
    end else if (en) begin
      ve1_q <= vf;
      ve2_q <= ve1_q;
    end
  end

  // ---------------------------------------------------------------- output register and skid
  qte_pkg::result_t out_q, skid_q;
  logic             out_valid_q, skid_valid_q;
  logic             take;

  assign take = out_valid_q && !out_stall_i;
  assign en   = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (ve2_q) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (ve2_q) begin
      if (out_valid_q && !take) begin
        skid_q <= res_q;
      end else begin
        out_q <= res_q;
      end
    end
  end

  assign in_stall_o        = skid_valid_q;
  assign out_valid_o       = out_valid_q;
  assign roll_angle_o      = out_q.roll;
  assign pitch_angle_o     = out_q.pitch;
  assign yaw_angle_o       = out_q.yaw;
  assign pitch_saturated_o = out_q.sat;

endmodule

// ===== rtl/qte_checker.sv =====
module qte_assertions (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [qte_pkg::OW-1:0] roll_angle_o,
  input logic signed [qte_pkg::OW-1:0] pitch_angle_o,
  input logic signed [qte_pkg::OW-1:0] yaw_angle_o,
  input logic                          pitch_saturated_o
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("outputs active in reset");

  // input only backs up behind a held result
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_stall_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !in_stall_o)
    else $error("input still stalled after result taken");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(roll_angle_o)
      && $stable(pitch_angle_o) && $stable(yaw_angle_o) && $stable(pitch_saturated_o))
    else $error("stalled transaction changed");

  // clamped pitch is exactly +-pi/2 in either unit
  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pitch_saturated_o |->
      pitch_angle_o == 16'sd12868 || pitch_angle_o == -16'sd12868 ||
      pitch_angle_o == 16'sd11520 || pitch_angle_o == -16'sd11520)
    else $error("clamped pitch not at right angle");

endmodule

bind quaternion_to_euler_angles_top qte_assertions u_qte_assertions (.*);
